### hw/rtl/animation_easing_curve_macros.svh
// Assertion macros used by animation_easing_curve.sv, which checks itself.
`ifndef ANIMATION_EASING_CURVE_MACROS_SVH
`define ANIMATION_EASING_CURVE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aec check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aec check failed");

`endif

### hw/rtl/aec_pkg.sv
// ---------------------------------------------------------------------------
// aec_pkg
// Types, constants and the quarter-wave sine table for the easing curve.
// ---------------------------------------------------------------------------
`default_nettype none
package aec_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int P_W              = FRAC_BITS + 1;
   localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SEG_W            = $clog2(SINE_TABLE_DEPTH);
   localparam logic [P_W-1:0] ONE_FX  = P_W'(1) << FRAC_BITS;
   localparam logic [P_W-1:0] HALF_FX = P_W'(1) << (FRAC_BITS - 1);

   // divider: one quotient bit per step, a few steps per register stage
   localparam int DIV_STEPS     = FRAC_BITS + 1;
   localparam int STEPS_PER_STG = 4;
   localparam int DIV_STAGES    = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;

   typedef enum logic [3:0] {
      CURVE_STILL      = 4'd0,
      CURVE_LINEAR     = 4'd1,
      CURVE_SINE_INOUT = 4'd2,
      CURVE_SINE_IN    = 4'd3,
      CURVE_SINE_OUT   = 4'd4,
      CURVE_QUAD_INOUT = 4'd5,
      CURVE_QUAD_IN    = 4'd6,
      CURVE_QUAD_OUT   = 4'd7,
      CURVE_CUBE_INOUT = 4'd8,
      CURVE_CUBE_IN    = 4'd9,
      CURVE_CUBE_OUT   = 4'd10
   } curve_type;

   typedef struct packed {
      logic [3:0] opcode;
      logic       sat;
   } meta_type;

   typedef logic [P_W-1:0] wave_table_type [0:SINE_TABLE_DEPTH];

   // Taylor series of sin through the 13th power in Q30, rounded to FRAC_BITS
   function automatic wave_table_type build_wave();
      wave_table_type    t;
      longint unsigned   a, a2, term, sum, v;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         a    = (64'd1686629713 * 64'(k)) / SINE_TABLE_DEPTH;
         a2   = (a * a) >> 30;
         term = a;
         sum  = a;
         term = ((term * a2) >> 30) / 6;   sum = sum - term;
         term = ((term * a2) >> 30) / 20;  sum = sum + term;
         term = ((term * a2) >> 30) / 42;  sum = sum - term;
         term = ((term * a2) >> 30) / 72;  sum = sum + term;
         term = ((term * a2) >> 30) / 110; sum = sum - term;
         term = ((term * a2) >> 30) / 156; sum = sum + term;
         v = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         if (v > 64'(ONE_FX)) v = 64'(ONE_FX);
         t[k] = P_W'(v);
      end
      return t;
   endfunction

   localparam wave_table_type QUARTER_WAVE = build_wave();

endpackage
`default_nettype wire

### hw/rtl/aec_div.sv
// ---------------------------------------------------------------------------
// aec_div
// Pipelined restoring divider: progress fraction = (index << FRAC_BITS) / count.
// ---------------------------------------------------------------------------
`default_nettype none
module aec_div (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  wire                      in_valid,
   input  wire  [15:0]              frame_index,
   input  wire  [15:0]              frame_count,
   input  aec_pkg::meta_type        in_meta,
   output logic                     out_valid,
   output logic [aec_pkg::P_W-1:0]  out_p,
   output aec_pkg::meta_type        out_meta
);
   import aec_pkg::*;

   logic             valid_ff [DIV_STAGES];
   logic [16:0]      rem_ff   [DIV_STAGES];
   logic [P_W-1:0]   quot_ff  [DIV_STAGES];
   logic [15:0]      cnt_ff   [DIV_STAGES];
   meta_type         meta_ff  [DIV_STAGES];

   logic [16:0]      rem_in   [DIV_STAGES];
   logic [P_W-1:0]   quot_in  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [16:0]    rem_src;
      logic [P_W-1:0] quot_src;
      logic [15:0]    cnt_src;

      assign rem_src  = (s == 0) ? {1'b0, frame_index} : rem_ff[(s == 0) ? 0 : s-1];
      assign quot_src = (s == 0) ? '0 : quot_ff[(s == 0) ? 0 : s-1];
      assign cnt_src  = (s == 0) ? frame_count : cnt_ff[(s == 0) ? 0 : s-1];

      always_comb begin
         logic [17:0]    r;
         logic [P_W-1:0] q;
         r = {1'b0, rem_src};
         q = quot_src;
         for (int t = 0; t < STEPS_PER_STG; t++) begin
            if (s * STEPS_PER_STG + t < DIV_STEPS) begin
               // first step compares the index itself, later ones shift in a zero
               if (s * STEPS_PER_STG + t != 0) r = {r[16:0], 1'b0};
               if (r >= {2'b00, cnt_src}) begin
                  r = r - {2'b00, cnt_src};
                  q = {q[P_W-2:0], 1'b1};
               end else begin
                  q = {q[P_W-2:0], 1'b0};
               end
            end
         end
         rem_in[s]  = r[16:0];
         quot_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
            cnt_ff[s]  <= cnt_src;
            meta_ff[s] <= (s == 0) ? in_meta : meta_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_meta  = meta_ff[DIV_STAGES-1];
   assign out_p     = meta_ff[DIV_STAGES-1].sat ? ONE_FX : quot_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/aec_curve.sv
// ---------------------------------------------------------------------------
// aec_curve
// Four-stage easing curve: operand prep, table/square, interp/cube, combine.
// ---------------------------------------------------------------------------
`default_nettype none
module aec_curve (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  wire                      in_valid,
   input  wire  [aec_pkg::P_W-1:0]  in_p,
   input  aec_pkg::meta_type        in_meta,
   output logic                     out_valid,
   output logic [aec_pkg::P_W-1:0]  progress,
   output logic                     saturated
);
   import aec_pkg::*;

   typedef struct packed {
      meta_type       meta;
      logic [P_W-1:0] p;
      logic           le_half;
      logic           lt_half;
   } item_type;

   // stage 1: curve operand
   logic           v1_ff;
   item_type       it1_ff;
   logic [P_W-1:0] u1_ff, x1_ff;
   logic [P_W-1:0] u1_in, x1_in;
   logic           le_half, lt_half;

   assign le_half = in_p <= HALF_FX;
   assign lt_half = in_p <  HALF_FX;

   always_comb begin
      case (in_meta.opcode)
         CURVE_SINE_INOUT: u1_in = le_half ? ONE_FX - {in_p[P_W-2:0], 1'b0}
                                           : {in_p[P_W-2:0], 1'b0} - ONE_FX;
         CURVE_SINE_IN:    u1_in = ONE_FX - in_p;
         default:          u1_in = in_p;
      endcase
      case (in_meta.opcode)
         CURVE_QUAD_INOUT, CURVE_CUBE_INOUT:
            x1_in = lt_half ? {in_p[P_W-2:0], 1'b0}
                            : {ONE_FX[P_W-2:0], 1'b0} - {in_p[P_W-2:0], 1'b0};
         CURVE_QUAD_OUT, CURVE_CUBE_OUT: x1_in = ONE_FX - in_p;
         default:                        x1_in = in_p;
      endcase
   end

   // stage 2: table lookup and square
   logic                  v2_ff;
   item_type              it2_ff;
   logic [P_W-1:0]        lo2_ff, diff2_ff, sq2_ff, x2_ff;
   logic [FRAC_BITS-1:0]  frac2_ff;
   logic [IDX_W-1:0]      seg, seg_hi;
   logic [P_W-1:0]        lo2_in, hi2_in;
   logic [2*P_W-1:0]      sq_full;

   assign seg     = IDX_W'(u1_ff >> (FRAC_BITS - SEG_W));
   assign seg_hi  = (seg == IDX_W'(SINE_TABLE_DEPTH)) ? seg : seg + IDX_W'(1);
   assign lo2_in  = QUARTER_WAVE[seg];
   assign hi2_in  = QUARTER_WAVE[seg_hi];
   assign sq_full = x1_ff * x1_ff + (2*P_W)'(HALF_FX);

   // stage 3: interpolation and cube
   logic              v3_ff;
   item_type          it3_ff;
   logic [P_W-1:0]    sine3_ff, poly3_ff;
   logic [2*P_W-1:0]  interp_full, cube_full;
   logic              cubic;

   assign interp_full = diff2_ff * {1'b0, frac2_ff};
   assign cube_full   = sq2_ff * x2_ff + (2*P_W)'(HALF_FX);
   assign cubic = (it2_ff.meta.opcode == CURVE_CUBE_INOUT) ||
                  (it2_ff.meta.opcode == CURVE_CUBE_IN) ||
                  (it2_ff.meta.opcode == CURVE_CUBE_OUT);

   // stage 4: final form
   logic           v4_ff;
   logic [P_W-1:0] res4_ff, res4_in;
   logic           sat4_ff;
   logic [P_W:0]   sine_sum;

   // one extra bit so that 1.0 + 1.0 does not wrap before the halving
   assign sine_sum = {1'b0, ONE_FX} + {1'b0, sine3_ff};

   always_comb begin
      case (it3_ff.meta.opcode)
         CURVE_STILL:      res4_in = ONE_FX;
         CURVE_SINE_INOUT: res4_in = it3_ff.le_half ? (ONE_FX - sine3_ff) >> 1
                                                     : P_W'(sine_sum >> 1);
         CURVE_SINE_IN:    res4_in = ONE_FX - sine3_ff;
         CURVE_SINE_OUT:   res4_in = sine3_ff;
         CURVE_QUAD_INOUT, CURVE_CUBE_INOUT:
            res4_in = it3_ff.lt_half ? poly3_ff >> 1 : ONE_FX - (poly3_ff >> 1);
         CURVE_QUAD_IN, CURVE_CUBE_IN:   res4_in = poly3_ff;
         CURVE_QUAD_OUT, CURVE_CUBE_OUT: res4_in = ONE_FX - poly3_ff;
         default:          res4_in = it3_ff.p;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         it1_ff   <= '{meta: in_meta, p: in_p, le_half: le_half, lt_half: lt_half};
         u1_ff    <= u1_in;
         x1_ff    <= x1_in;

         it2_ff   <= it1_ff;
         lo2_ff   <= lo2_in;
         diff2_ff <= (hi2_in < lo2_in) ? '0 : hi2_in - lo2_in;
         frac2_ff <= FRAC_BITS'(u1_ff << SEG_W);
         sq2_ff   <= P_W'(sq_full >> FRAC_BITS);
         x2_ff    <= x1_ff;

         it3_ff   <= it2_ff;
         sine3_ff <= lo2_ff + P_W'(interp_full >> FRAC_BITS);
         poly3_ff <= cubic ? P_W'(cube_full >> FRAC_BITS) : sq2_ff;

         res4_ff  <= res4_in;
         sat4_ff  <= it3_ff.meta.sat;
      end
   end

   assign out_valid = v4_ff;
   assign progress  = res4_ff;
   assign saturated = sat4_ff;

endmodule
`default_nettype wire

### hw/rtl/animation_easing_curve.sv
// Pipeline: 5 divider stages, then 4 curve stages, from req transaction to rsp valid.
// Throughput: one transaction per cycle; the whole pipeline holds while rsp is stalled.
// The divider retires up to four quotient bits per register stage.
// Reset: synchronous, active high; clears all stage valid bits, no table fill needed.
// ---------------------------------------------------------------------------
// animation_easing_curve
// Eased animation progress from frame index, frame count and curve selector.
// ---------------------------------------------------------------------------
`default_nettype none
`include "animation_easing_curve_macros.svh"
module animation_easing_curve (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [15:0] frame_index, [31:16] frame_count
   input  wire  [3:0]  req_tuser,   // [3:0] opcode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] progress, [23:17] zero
   output logic [0:0]  rsp_tuser    // [0] saturated
);
   import aec_pkg::*;

   logic           advance;
   logic [15:0]    frame_index, frame_count;
   meta_type       req_meta, div_meta;
   logic           div_valid;
   logic [P_W-1:0] div_p, progress;
   logic           saturated;

   // advance everything unless a finished result is waiting
   assign advance     = !rsp_tvalid || rsp_tready;
   assign req_tready  = advance;
   assign frame_index = req_tdata[15:0];
   assign frame_count = req_tdata[31:16];
   assign req_meta    = '{opcode: req_tuser,
                          sat: (frame_count == 16'd0) || (frame_index > frame_count)};

   aec_div u_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_tvalid),
      .frame_index (frame_index),
      .frame_count (frame_count),
      .in_meta     (req_meta),
      .out_valid   (div_valid),
      .out_p       (div_p),
      .out_meta    (div_meta)
   );

   aec_curve u_curve (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_p      (div_p),
      .in_meta   (div_meta),
      .out_valid (rsp_tvalid),
      .progress  (progress),
      .saturated (saturated)
   );

   assign rsp_tdata = {{(24-P_W){1'b0}}, progress};
   assign rsp_tuser = saturated;

   `AEC_ASSERT_NOW(a_progress_bound, clock, reset, rsp_tvalid, progress <= ONE_FX)
   `AEC_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `AEC_ASSERT_NOW(a_div_sat_one, clock, reset, div_valid && div_meta.sat, div_p == ONE_FX)

endmodule
`default_nettype wire
